### sv/skfb_pkg.sv
`default_nettype none
package skfb_pkg;

   localparam int CHANNELS_DEF  = 4;
   localparam int FRAC_BITS_DEF = 16;

   localparam int CHAN_W     = 2;
   localparam int DATA_W     = 32;
   localparam int UNC_W      = 31;
   localparam int GAIN_W     = 17;
   localparam int CG_W       = 17;
   localparam int PD_W       = 21;
   localparam int MD_W       = 21;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 21;
   localparam int REQ_DATA_W = 2 * DATA_W;
   localparam int RSP_DATA_W = 80;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CONTROL_GAIN = 2'd0,
      REG_PROCESS_DEV  = 2'd1,
      REG_MEASURE_DEV  = 2'd2
   } reg_index_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_PREDICT,
      OP_NOISE,
      OP_SQUARE,
      OP_SUM,
      OP_DENOM,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_GAIN,
      OP_PRODUCT,
      OP_CORRECT,
      OP_COMMIT
   } op_type;

   typedef struct packed {
      op_type op;
   } dp_cmd_type;

endpackage
`default_nettype wire

### sv/skfb_ctrl.sv
`default_nettype none
module skfb_ctrl #(
   parameter int FRAC_BITS = skfb_pkg::FRAC_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output skfb_pkg::dp_cmd_type      cmd
);

   localparam int CNT_W = $clog2(FRAC_BITS + 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREDICT,
      ST_NOISE,
      ST_SQUARE,
      ST_SUM,
      ST_DENOM,
      ST_DIV_INIT,
      ST_DIVIDE,
      ST_GAIN,
      ST_PRODUCT,
      ST_CORRECT,
      ST_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd.op       = skfb_pkg::OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = skfb_pkg::OP_LOAD;
               state_in = ST_PREDICT;
            end
         end
         ST_PREDICT: begin
            cmd.op   = skfb_pkg::OP_PREDICT;
            state_in = ST_NOISE;
         end
         ST_NOISE: begin
            cmd.op   = skfb_pkg::OP_NOISE;
            state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            cmd.op   = skfb_pkg::OP_SQUARE;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.op   = skfb_pkg::OP_SUM;
            state_in = ST_DENOM;
         end
         ST_DENOM: begin
            cmd.op   = skfb_pkg::OP_DENOM;
            state_in = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            cmd.op   = skfb_pkg::OP_DIV_INIT;
            cnt_in   = '0;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.op = skfb_pkg::OP_DIV_STEP;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(FRAC_BITS)) begin
               state_in = ST_GAIN;
            end
         end
         ST_GAIN: begin
            cmd.op   = skfb_pkg::OP_GAIN;
            state_in = ST_PRODUCT;
         end
         ST_PRODUCT: begin
            cmd.op   = skfb_pkg::OP_PRODUCT;
            state_in = ST_CORRECT;
         end
         ST_CORRECT: begin
            cmd.op   = skfb_pkg::OP_CORRECT;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.op       = skfb_pkg::OP_COMMIT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule
`default_nettype wire

### sv/skfb_datapath.sv
`default_nettype none
module skfb_datapath #(
   parameter int CHANNELS  = skfb_pkg::CHANNELS_DEF,
   parameter int FRAC_BITS = skfb_pkg::FRAC_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire skfb_pkg::dp_cmd_type               cmd,
   input  wire logic [skfb_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  wire logic [skfb_pkg::CHAN_W-1:0]        req_tuser,
   input  wire logic                               csr_valid,
   input  wire logic [skfb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [skfb_pkg::CSR_DATA_W-1:0]    csr_data,
   output logic [skfb_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   output logic [skfb_pkg::CHAN_W-1:0]             rsp_tuser
);

   localparam int DATA_W = skfb_pkg::DATA_W;
   localparam int UNC_W  = skfb_pkg::UNC_W;
   localparam int CG_W   = skfb_pkg::CG_W;
   localparam int PD_W   = skfb_pkg::PD_W;
   localparam int MD_W   = skfb_pkg::MD_W;
   localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam longint unsigned HALF = 64'd1 << (FRAC_BITS - 1);

   localparam int PA_W   = CG_W + 1 + DATA_W;
   localparam int PA_S_W = PA_W + 1;
   localparam int XS_W   = PA_S_W + 1;
   localparam int PB_W   = CG_W + PD_W;
   localparam int PB_S_W = PB_W + 1;
   localparam int CP_W   = PB_S_W - FRAC_BITS;
   localparam int PC_W   = 2 * MD_W;
   localparam int PC_S_W = PC_W + 1;
   localparam int RM_W   = PC_S_W - FRAC_BITS;
   localparam int SQ_W   = 2 * CP_W;
   localparam int SQ_S_W = ((SQ_W > FRAC_BITS) ? SQ_W : FRAC_BITS) + 1;
   localparam int SQR_W  = SQ_S_W - FRAC_BITS;
   localparam int PPS_W  = ((SQR_W > UNC_W) ? SQR_W : UNC_W) + 1;
   localparam int DN_W   = ((RM_W > UNC_W) ? RM_W : UNC_W) + 1;
   localparam int NM_W   = (((UNC_W + FRAC_BITS) > DN_W) ? (UNC_W + FRAC_BITS) : DN_W) + 1;
   localparam int R_W    = DN_W + 1;
   localparam int G_W    = FRAC_BITS + 1;
   localparam int DF_W   = DATA_W + 1;
   localparam int PE_W   = G_W + 1 + DF_W;
   localparam int PE_S_W = PE_W + 1;
   localparam int ES_W   = PE_S_W + 1;
   localparam int PU_W   = G_W + UNC_W;
   localparam int PU_S_W = PU_W + 1;
   localparam int UR_W   = PU_S_W - FRAC_BITS;

   localparam logic [G_W-1:0]   ONE_G   = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [CG_W-1:0]  CG_RST  = CG_W'(((64'd5 << FRAC_BITS) + 64'd500) / 64'd1000);
   localparam logic [PD_W-1:0]  PD_RST  = PD_W'(64'd3 << FRAC_BITS);
   localparam logic [MD_W-1:0]  MD_RST  = MD_W'(64'd2 << FRAC_BITS);
   localparam logic [UNC_W-1:0] UNC_RST = UNC_W'(64'd4 << FRAC_BITS);

   // configuration and per-channel state
   logic [CG_W-1:0]           cg_ff;
   logic [PD_W-1:0]           pd_ff;
   logic [MD_W-1:0]           md_ff;
   logic signed [DATA_W-1:0]  est_store_ff [CHANNELS];
   logic [UNC_W-1:0]          unc_store_ff [CHANNELS];

   // working registers
   logic [skfb_pkg::CHAN_W-1:0] chan_ff;
   logic [CH_W-1:0]           idx_ff, idx_in;
   logic signed [DATA_W-1:0]  rate_ff, meas_ff;
   logic signed [PA_W-1:0]    prod_a_ff;
   logic [PB_W-1:0]           prod_b_ff;
   logic [PC_W-1:0]           prod_c_ff;
   logic signed [DATA_W-1:0]  xp_ff, xp_in;
   logic [CP_W-1:0]           cp_ff, cp_in;
   logic [SQ_W-1:0]           sq_ff;
   logic [RM_W-1:0]           rm_ff, rm_in;
   logic [UNC_W-1:0]          pp_ff, pp_in;
   logic [DN_W-1:0]           denom_ff, denom_in;
   logic [R_W-1:0]            rem_ff, rem_in, rem_step;
   logic [G_W-1:0]            quo_ff, quo_in, quo_step;
   logic                      zero_ff;
   logic [G_W-1:0]            gain_ff, gain_in;
   logic signed [DF_W-1:0]    diff_ff, diff_in;
   logic signed [PE_W-1:0]    prod_e_ff;
   logic [PU_W-1:0]           prod_u_ff;
   logic signed [DATA_W-1:0]  est_res_ff, est_res_in;
   logic [UNC_W-1:0]          unc_res_ff, unc_res_in;

   logic [skfb_pkg::CHAN_W-1:0]  rsp_chan_ff;
   logic signed [DATA_W-1:0]     rsp_est_ff;
   logic [UNC_W-1:0]             rsp_unc_ff;
   logic [skfb_pkg::GAIN_W-1:0]  rsp_gain_ff;

   // combinational intermediates
   logic [4:0]                wrap;
   logic signed [PA_S_W-1:0]  pa_sum, pa_rnd;
   logic signed [XS_W-1:0]    xs;
   logic [PB_S_W-1:0]         pb_sum;
   logic [PC_S_W-1:0]         pc_sum;
   logic [SQ_S_W-1:0]         sq_sum;
   logic [SQR_W-1:0]          sq_rnd;
   logic [PPS_W-1:0]          pp_sum;
   logic [NM_W-1:0]           num;
   logic [R_W-1:0]            trial;
   logic                      take;
   logic signed [PE_S_W-1:0]  pe_sum, pe_rnd;
   logic signed [ES_W-1:0]    es;
   logic [PU_S_W-1:0]         pu_sum;
   logic [UR_W-1:0]           unc_rnd;

   always_comb begin
      wrap = 5'(req_tuser);
      for (int k = 0; k < 3; k++) begin
         if (wrap >= 5'(CHANNELS)) begin
            wrap = wrap - 5'(CHANNELS);
         end
      end
      idx_in = CH_W'(wrap);

      // predicted estimate
      pa_sum = PA_S_W'(prod_a_ff) + PA_S_W'(HALF);
      pa_rnd = pa_sum >>> FRAC_BITS;
      xs     = XS_W'(est_store_ff[idx_ff]) + XS_W'(pa_rnd);
      if ((&xs[XS_W-1:DATA_W-1]) || !(|xs[XS_W-1:DATA_W-1])) begin
         xp_in = xs[DATA_W-1:0];
      end else begin
         xp_in = xs[XS_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end

      pb_sum = PB_S_W'(prod_b_ff) + PB_S_W'(HALF);
      cp_in  = CP_W'(pb_sum >> FRAC_BITS);
      pc_sum = PC_S_W'(prod_c_ff) + PC_S_W'(HALF);
      rm_in  = RM_W'(pc_sum >> FRAC_BITS);

      // predicted variance
      sq_sum = SQ_S_W'(sq_ff) + SQ_S_W'(HALF);
      sq_rnd = SQR_W'(sq_sum >> FRAC_BITS);
      pp_sum = PPS_W'(unc_store_ff[idx_ff]) + PPS_W'(sq_rnd);
      pp_in  = (|pp_sum[PPS_W-1:UNC_W]) ? '1 : pp_sum[UNC_W-1:0];

      denom_in = DN_W'(pp_ff) + DN_W'(rm_ff);

      // gain divider, restoring, one quotient bit per step
      num    = (NM_W'(pp_ff) << FRAC_BITS) + NM_W'(denom_ff >> 1);
      rem_in = R_W'(num >> (FRAC_BITS + 1));
      quo_in = num[FRAC_BITS:0];
      trial  = {rem_ff[R_W-2:0], quo_ff[G_W-1]};
      take   = (trial >= R_W'(denom_ff));
      rem_step = take ? (trial - R_W'(denom_ff)) : trial;
      quo_step = {quo_ff[G_W-2:0], take};

      if (zero_ff) begin
         gain_in = '0;
      end else begin
         gain_in = (quo_ff > ONE_G) ? ONE_G : quo_ff;
      end
      diff_in = DF_W'(meas_ff) - DF_W'(xp_ff);

      // correction
      pe_sum = PE_S_W'(prod_e_ff) + PE_S_W'(HALF);
      pe_rnd = pe_sum >>> FRAC_BITS;
      es     = ES_W'(xp_ff) + ES_W'(pe_rnd);
      if ((&es[ES_W-1:DATA_W-1]) || !(|es[ES_W-1:DATA_W-1])) begin
         est_res_in = es[DATA_W-1:0];
      end else begin
         est_res_in = es[ES_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end

      pu_sum     = PU_S_W'(prod_u_ff) + PU_S_W'(HALF);
      unc_rnd    = UR_W'(pu_sum >> FRAC_BITS);
      unc_res_in = (|unc_rnd[UR_W-1:UNC_W]) ? '1 : unc_rnd[UNC_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cg_ff <= CG_RST;
         pd_ff <= PD_RST;
         md_ff <= MD_RST;
         for (int i = 0; i < CHANNELS; i++) begin
            est_store_ff[i] <= '0;
            unc_store_ff[i] <= (i < 3) ? UNC_RST : '0;
         end
      end else begin
         if (csr_valid) begin
            case (csr_index)
               skfb_pkg::REG_CONTROL_GAIN: cg_ff <= csr_data[CG_W-1:0];
               skfb_pkg::REG_PROCESS_DEV:  pd_ff <= csr_data[PD_W-1:0];
               skfb_pkg::REG_MEASURE_DEV:  md_ff <= csr_data[MD_W-1:0];
               default: begin
               end
            endcase
         end
         if (cmd.op == skfb_pkg::OP_COMMIT) begin
            est_store_ff[idx_ff] <= est_res_ff;
            unc_store_ff[idx_ff] <= unc_res_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         skfb_pkg::OP_LOAD: begin
            chan_ff <= req_tuser;
            idx_ff  <= idx_in;
            rate_ff <= req_tdata[DATA_W-1:0];
            meas_ff <= req_tdata[2*DATA_W-1:DATA_W];
         end
         skfb_pkg::OP_PREDICT: begin
            prod_a_ff <= PA_W'($signed({1'b0, cg_ff})) * PA_W'(rate_ff);
            prod_b_ff <= PB_W'(cg_ff) * PB_W'(pd_ff);
         end
         skfb_pkg::OP_NOISE: begin
            xp_ff     <= xp_in;
            cp_ff     <= cp_in;
            prod_c_ff <= PC_W'(md_ff) * PC_W'(md_ff);
         end
         skfb_pkg::OP_SQUARE: begin
            sq_ff <= SQ_W'(cp_ff) * SQ_W'(cp_ff);
            rm_ff <= rm_in;
         end
         skfb_pkg::OP_SUM: begin
            pp_ff <= pp_in;
         end
         skfb_pkg::OP_DENOM: begin
            denom_ff <= denom_in;
         end
         skfb_pkg::OP_DIV_INIT: begin
            rem_ff  <= rem_in;
            quo_ff  <= quo_in;
            zero_ff <= (denom_ff == '0);
         end
         skfb_pkg::OP_DIV_STEP: begin
            rem_ff <= rem_step;
            quo_ff <= quo_step;
         end
         skfb_pkg::OP_GAIN: begin
            gain_ff <= gain_in;
            diff_ff <= diff_in;
         end
         skfb_pkg::OP_PRODUCT: begin
            prod_e_ff <= PE_W'($signed({1'b0, gain_ff})) * PE_W'(diff_ff);
            prod_u_ff <= PU_W'(ONE_G - gain_ff) * PU_W'(pp_ff);
         end
         skfb_pkg::OP_CORRECT: begin
            est_res_ff <= est_res_in;
            unc_res_ff <= unc_res_in;
         end
         skfb_pkg::OP_COMMIT: begin
            rsp_chan_ff <= chan_ff;
            rsp_est_ff  <= est_res_ff;
            rsp_unc_ff  <= unc_res_ff;
            rsp_gain_ff <= skfb_pkg::GAIN_W'(gain_ff);
         end
         default: begin
         end
      endcase
   end

   assign rsp_tdata = {rsp_gain_ff, rsp_unc_ff, rsp_est_ff};
   assign rsp_tuser = rsp_chan_ff;

endmodule
`default_nettype wire

### sv/scalar_kalman_filter_bank.sv
`default_nettype none
// Bank of CHANNELS scalar Kalman filters, signed fixed point with FRAC_BITS
// fraction bits. Each req beat names a channel (req_tuser) and carries a rate
// input and a measurement; one rsp beat returns the corrected estimate, its
// variance and the gain used, and the channel's state is updated. A channel
// index at or above CHANNELS wraps modulo CHANNELS; rsp_tuser echoes it
// unchanged. One item is in work at a time; from accept to the next accept
// it runs ten datapath steps, a restoring divider for the gain producing
// one quotient bit per cycle, and a commit step. The estimate is Q16.16 at
// the default FRAC_BITS. The result sits in an output register, so the next
// item is taken while the previous beat waits on rsp_tready. csr_ready is
// always high; write registers only while idle.
module scalar_kalman_filter_bank #(
   parameter int CHANNELS  = skfb_pkg::CHANNELS_DEF,
   parameter int FRAC_BITS = skfb_pkg::FRAC_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // [31:0] rate_input, [63:32] measurement
   input  wire logic [skfb_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [1:0] channel
   input  wire logic [skfb_pkg::CHAN_W-1:0]        req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [31:0] estimate, [62:32] uncertainty, [79:63] gain
   output logic [skfb_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   // [1:0] out_channel
   output logic [skfb_pkg::CHAN_W-1:0]             rsp_tuser,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [skfb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [skfb_pkg::CSR_DATA_W-1:0]    csr_data
);

   skfb_pkg::dp_cmd_type cmd;

   skfb_ctrl #(
      .FRAC_BITS (FRAC_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   skfb_datapath #(
      .CHANNELS  (CHANNELS),
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   assign csr_ready = 1'b1;

endmodule
`default_nettype wire
